@@ sv/motion_orientation_classifier_top_defines.svh @@
// Assertion macros shared by the classifier RTL.
// Included by moc_motion_track and motion_orientation_classifier_top.
`ifndef MOTION_ORIENTATION_CLASSIFIER_TOP_DEFINES_SVH
`define MOTION_ORIENTATION_CLASSIFIER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MOC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("classifier check failed");

`define MOC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("classifier check failed");

`else

`define MOC_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define MOC_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/moc_pkg.sv @@
// Types, codes and helpers for the motion and orientation classifier.
// No dependencies; used by every module of the block.
package moc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_CNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_GRAV_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_GRAV_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_OTHER    = 3'd5;

    localparam logic [2:0] FACE_Z_UP   = 3'd0;
    localparam logic [2:0] FACE_Z_DOWN = 3'd1;
    localparam logic [2:0] FACE_X_UP   = 3'd2;
    localparam logic [2:0] FACE_X_DOWN = 3'd3;
    localparam logic [2:0] FACE_Y_UP   = 3'd4;
    localparam logic [2:0] FACE_Y_DOWN = 3'd5;
    localparam logic [2:0] FACE_TILTED = 3'd6;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic signed [15:0] grav_x;
        logic signed [15:0] grav_y;
        logic signed [15:0] grav_z;
    } in_t;

    typedef struct packed {
        logic       is_moving;
        logic       is_stable;
        logic [2:0] face;
        logic       flat_on_table;
    } out_t;

    typedef struct packed {
        logic [31:0] motion_sq;
        logic [31:0] stable_sq;
        logic [9:0]  count_req;
        logic [15:0] grav_min;
        logic [15:0] grav_max;
        logic [15:0] other_max;
    } cfg_t;

    typedef struct packed {
        logic [30:0] rx_sq;
        logic [30:0] ry_sq;
        logic [30:0] rz_sq;
        logic [2:0]  face;
    } sq_t;

    function automatic logic [16:0] mag16(input logic [15:0] v);
        logic [16:0] m;
        m = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
        return m;
    endfunction

endpackage

@@ sv/motion_orientation_classifier_top.sv @@
// Top level of the motion and orientation classifier: handshake and pipeline.
// Depends on moc_pkg, moc_cfg_regs, moc_square_stage, moc_motion_track.
//
//  channel | signals                       | accepted when
//  --------+-------------------------------+---------------------------
//  input   | in_valid, in_stall, in_data   | in_valid && !in_stall
//  output  | out_valid, out_stall, out_data| out_valid && !out_stall
//  config  | cfg_we, cfg_idx, cfg_data     | cfg_we
//
// Three register stages: input, squares and face, state and result.
// One transaction per cycle while out_stall is low; out_valid rises once the item has passed
// the input, squares and face, and result registers. Reset clears the stage valid bits, the
// motion flag and the still counter, and loads the register defaults.
// out_stall holds the result stage; upstream stages fill bubbles, then stall.
`include "motion_orientation_classifier_top_defines.svh"

module motion_orientation_classifier_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  moc_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output moc_pkg::out_t                  out_data,
    input  logic                           cfg_we,
    input  logic [moc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [moc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import moc_pkg::*;

    cfg_t cfg;
    in_t  in_reg;
    sq_t  sq;
    logic v1_reg;
    logic v1_next;
    logic v2_reg;
    logic v2_next;
    logic v3_reg;
    logic v3_next;
    logic ready1;
    logic ready2;
    logic ready3;

    assign ready3 = !v3_reg || !out_stall;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign in_stall = !ready1;

    assign v1_next = ready1 ? in_valid : v1_reg;
    assign v2_next = ready2 ? v1_reg : v2_reg;
    assign v3_next = ready3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            in_reg <= in_data;
        end
    end

    moc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    moc_square_stage u_square (
        .clk     (clk),
        .load    (ready2 && v1_reg),
        .in_item (in_reg),
        .cfg     (cfg),
        .sq      (sq)
    );

    moc_motion_track u_motion (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (ready3 && v2_reg),
        .sq    (sq),
        .cfg   (cfg),
        .res   (out_data)
    );

    assign out_valid = v3_reg;

    `MOC_ASSERT_IMP(a_moving_not_stable, clk, rst_n, out_valid && out_data.is_moving, !out_data.is_stable)
    `MOC_ASSERT_IMP(a_flat_matches_face, clk, rst_n, out_valid, out_data.flat_on_table == (out_data.face != FACE_TILTED))
    `MOC_ASSERT_NXT(a_full_pipe_stalls, clk, rst_n, v1_reg && v2_reg && v3_reg && out_stall, v1_reg && v2_reg && v3_reg)

endmodule

@@ sv/moc_cfg_regs.sv @@
// Configuration register file; the motion and stable thresholds are stored squared.
// Depends on moc_pkg.
module moc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [moc_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [moc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output moc_pkg::cfg_t                     cfg
);
    import moc_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic [31:0] data_sq;

    assign data_sq = {16'd0, cfg_data} * {16'd0, cfg_data};

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_MOTION_THR:    cfg_next.motion_sq = data_sq;
                CFG_STABLE_THR:    cfg_next.stable_sq = data_sq;
                CFG_STABLE_CNT:    cfg_next.count_req = cfg_data[9:0];
                CFG_FLAT_GRAV_MIN: cfg_next.grav_min  = cfg_data;
                CFG_FLAT_GRAV_MAX: cfg_next.grav_max  = cfg_data;
                CFG_FLAT_OTHER:    cfg_next.other_max = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motion_sq <= 32'd64;
            cfg_reg.stable_sq <= 32'd4;
            cfg_reg.count_req <= 10'd10;
            cfg_reg.grav_min  <= 16'd920;
            cfg_reg.grav_max  <= 16'd1050;
            cfg_reg.other_max <= 16'd350;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/moc_face_classify.sv @@
// Six-face orientation decode from gravity, priority Z, X, Y; tilted when no face matches.
// Depends on moc_pkg.
module moc_face_classify (
    input  logic signed [15:0] grav_x,
    input  logic signed [15:0] grav_y,
    input  logic signed [15:0] grav_z,
    input  moc_pkg::cfg_t      cfg,
    output logic [2:0]         face
);
    import moc_pkg::*;

    logic [16:0] gx;
    logic [16:0] gy;
    logic [16:0] gz;
    logic        al_x;
    logic        al_y;
    logic        al_z;
    logic        sm_x;
    logic        sm_y;
    logic        sm_z;

    assign gx = mag16(grav_x);
    assign gy = mag16(grav_y);
    assign gz = mag16(grav_z);

    assign al_x = (gx > {1'b0, cfg.grav_min}) && (gx < {1'b0, cfg.grav_max});
    assign al_y = (gy > {1'b0, cfg.grav_min}) && (gy < {1'b0, cfg.grav_max});
    assign al_z = (gz > {1'b0, cfg.grav_min}) && (gz < {1'b0, cfg.grav_max});
    assign sm_x = gx < {1'b0, cfg.other_max};
    assign sm_y = gy < {1'b0, cfg.other_max};
    assign sm_z = gz < {1'b0, cfg.other_max};

    always_comb
    begin
        if (al_z && sm_x && sm_y)
            face = grav_z[15] ? FACE_Z_UP : FACE_Z_DOWN;
        else if (al_x && sm_y && sm_z)
            face = grav_x[15] ? FACE_X_UP : FACE_X_DOWN;
        else if (al_y && sm_x && sm_z)
            face = grav_y[15] ? FACE_Y_UP : FACE_Y_DOWN;
        else
            face = FACE_TILTED;
    end

endmodule

@@ sv/moc_square_stage.sv @@
// Middle pipeline stage: squared gyro rates and face code, registered.
// Depends on moc_pkg and moc_face_classify.
module moc_square_stage (
    input  logic          clk,
    input  logic          load,
    input  moc_pkg::in_t  in_item,
    input  moc_pkg::cfg_t cfg,
    output moc_pkg::sq_t  sq
);
    import moc_pkg::*;

    sq_t         sq_reg;
    sq_t         sq_next;
    logic [16:0] mx;
    logic [16:0] my;
    logic [16:0] mz;
    logic [33:0] prod_x;
    logic [33:0] prod_y;
    logic [33:0] prod_z;
    logic [2:0]  face;

    assign mx = mag16(in_item.rate_x);
    assign my = mag16(in_item.rate_y);
    assign mz = mag16(in_item.rate_z);

    assign prod_x = {17'b0, mx} * {17'b0, mx};
    assign prod_y = {17'b0, my} * {17'b0, my};
    assign prod_z = {17'b0, mz} * {17'b0, mz};

    moc_face_classify u_face (
        .grav_x (in_item.grav_x),
        .grav_y (in_item.grav_y),
        .grav_z (in_item.grav_z),
        .cfg    (cfg),
        .face   (face)
    );

    always_comb
    begin
        sq_next.rx_sq = prod_x[30:0];
        sq_next.ry_sq = prod_y[30:0];
        sq_next.rz_sq = prod_z[30:0];
        sq_next.face  = face;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

@@ sv/moc_motion_track.sv @@
// Final stage: motion hysteresis state and the registered result.
// Depends on moc_pkg and the assertion macro header.
`include "motion_orientation_classifier_top_defines.svh"

module moc_motion_track (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  moc_pkg::sq_t  sq,
    input  moc_pkg::cfg_t cfg,
    output moc_pkg::out_t res
);
    import moc_pkg::*;

    logic        moving_reg;
    logic        moving_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] count_inc;
    logic [31:0] sum_sq;
    logic        over;
    logic        under;
    out_t        res_reg;
    out_t        res_next;

    assign sum_sq = {1'b0, sq.rx_sq} + {1'b0, sq.ry_sq} + {1'b0, sq.rz_sq};
    assign over   = sum_sq > cfg.motion_sq;
    assign under  = sum_sq < cfg.stable_sq;
    assign count_inc = (count_reg != COUNT_MAX) ? (count_reg + 16'd1) : count_reg;

    always_comb
    begin
        moving_next = moving_reg;
        count_next  = count_reg;
        if (over)
        begin
            moving_next = 1'b1;
            count_next  = 16'd0;
        end
        else if (under)
        begin
            count_next = count_inc;
            if (count_inc >= {6'd0, cfg.count_req})
                moving_next = 1'b0;
        end
        else if (count_reg != 16'd0)
        begin
            count_next = count_reg - 16'd1;
        end
        res_next.is_moving     = moving_next;
        res_next.is_stable     = !moving_next && (count_next >= {6'd0, cfg.count_req});
        res_next.face          = sq.face;
        res_next.flat_on_table = (sq.face != FACE_TILTED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_reg <= 1'b0;
            count_reg  <= 16'd0;
        end
        else if (load)
        begin
            moving_reg <= moving_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

    `MOC_ASSERT_NXT(a_motion_clears, clk, rst_n, load && over, moving_reg && (count_reg == 16'd0))
    `MOC_ASSERT_NXT(a_decay_by_one, clk, rst_n, load && !over && !under && (count_reg != 16'd0), count_reg == ($past(count_reg) - 16'd1))
    `MOC_ASSERT_NXT(a_state_in_result, clk, rst_n, load, res_reg.is_moving == moving_reg)

endmodule
